>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks used across the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/bole_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list engine package
// Opcodes, status codes and controller states of the ordered list engine.
// ----------------------------------------------------------------------------
package bole_pkg;

   typedef enum logic [2:0] {
      OP_APPEND       = 3'd0,
      OP_PREPEND      = 3'd1,
      OP_REMOVE_FIRST = 3'd2,
      OP_REMOVE_LAST  = 3'd3,
      OP_REMOVE_AT    = 3'd4,
      OP_REMOVE_VALUE = 3'd5,
      OP_INSERT_AT    = 3'd6,
      OP_DUMP         = 3'd7
   } opcode_type;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_EMPTY     = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_BAD_INDEX = 3'd3,
      STAT_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INSERT,
      S_REMOVE,
      S_SEARCH,
      S_DUMP
   } state_type;

endpackage

>>> hdl/bounded_ordered_list_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded ordered list engine
// Ordered list of up to CAPACITY signed words kept packed in one memory.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. It carries an
// opcode, a value and a position. Results appear on the rsp_ ports for one
// cycle each, marked by rsp_strobe; the receiver cannot stall them, and
// rsp_last_of_run flags the final result of a request.
// Append, a prepend or insert into an empty list or at the tail, and every
// request rejected as full, empty or bad index are answered at once: the
// result shows in the next cycle and busy stays low. An insert at index p
// shifts the tail up one entry a cycle. A remove at index p reads the entry
// and shifts the tail down. A remove by value scans from the head and then
// shifts. A dump reads one entry a cycle and gives one result a cycle.
// These rates come from the single memory read port and write port walking
// the list one entry per cycle.
// Reset empties the list at once; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_ordered_list_engine_top
   import bole_pkg::*;
#(
   parameter int CAPACITY = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_opcode,
   input  logic signed [31:0] req_item_value,
   input  logic [5:0]         req_position,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_element,
   output logic [2:0]         rsp_status,
   output logic [5:0]         rsp_length,
   output logic               rsp_last_of_run
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > 6) ? CW : 6;

   logic signed [31:0] mem [CAPACITY];

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic signed [31:0] val_ff, val_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [AW-1:0]      stop_ff, stop_in;
   logic [AW-1:0]      ptr_ff, ptr_in;
   logic               reading_ff, reading_in;
   logic               rvalid_ff, rvalid_in;
   logic [AW-1:0]      rdidx_ff, rdidx_in;
   logic signed [31:0] removed_ff, removed_in;
   logic signed [31:0] rdata_ff;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic signed [31:0] rsp_element_ff, rsp_element_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               mem_we;
   logic [AW-1:0]      wr_addr;
   logic signed [31:0] wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;

   logic               accept;
   logic               is_full;
   logic               is_empty;
   logic               pos_lt;
   logic               pos_gt;
   logic               done;
   logic               match;
   logic [XW-1:0]      pos_x;
   logic [XW-1:0]      cnt_x;
   logic [AW-1:0]      tail_idx;
   opcode_type         opcode;

   assign opcode   = opcode_type'(req_opcode);
   assign accept   = start && !busy;
   assign is_full  = (count_ff == CW'(CAPACITY));
   assign is_empty = (count_ff == '0);
   assign pos_x    = XW'(req_position);
   assign cnt_x    = XW'(count_ff);
   assign pos_lt   = (pos_x < cnt_x);
   assign pos_gt   = (pos_x > cnt_x);
   assign tail_idx = AW'(count_ff - 1'b1);
   assign done     = !reading_ff && !rvalid_ff;
   assign match    = rvalid_ff && (rdata_ff == val_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (opcode)
                  OP_PREPEND: begin
                     if (!is_full && !is_empty) state_in = S_INSERT;
                  end
                  OP_INSERT_AT: begin
                     if (!pos_gt && !is_full && pos_lt) state_in = S_INSERT;
                  end
                  OP_REMOVE_FIRST, OP_REMOVE_LAST, OP_REMOVE_AT: begin
                     if (!is_empty) state_in = S_REMOVE;
                  end
                  OP_REMOVE_VALUE: begin
                     if (!is_empty) state_in = S_SEARCH;
                  end
                  OP_DUMP: begin
                     if (!is_empty) state_in = S_DUMP;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_INSERT, S_REMOVE, S_DUMP: begin
            if (done) state_in = S_IDLE;
         end
         S_SEARCH: begin
            if (match) state_in = S_REMOVE;
            else if (done) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      count_in       = count_ff;
      val_in         = val_ff;
      pos_in         = pos_ff;
      stop_in        = stop_ff;
      ptr_in         = ptr_ff;
      reading_in     = reading_ff;
      rvalid_in      = 1'b0;
      rdidx_in       = ptr_ff;
      removed_in     = removed_ff;
      rsp_strobe_in  = 1'b0;
      rsp_element_in = '0;
      rsp_status_in  = STAT_OK;
      rsp_last_in    = 1'b0;
      mem_we         = 1'b0;
      wr_addr        = pos_ff;
      wr_data        = val_ff;
      rd_en          = 1'b0;
      rd_addr        = ptr_ff;

      if (state_ff != S_IDLE && reading_ff) begin
         rd_en     = 1'b1;
         rvalid_in = 1'b1;
         if (ptr_ff == stop_ff) begin
            reading_in = 1'b0;
         end else if (state_ff == S_INSERT) begin
            ptr_in = ptr_ff - 1'b1;
         end else begin
            ptr_in = ptr_ff + 1'b1;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               val_in        = req_item_value;
               rsp_strobe_in = 1'b1;
               rsp_last_in   = 1'b1;
               case (opcode)
                  OP_APPEND, OP_PREPEND, OP_INSERT_AT: begin
                     if (opcode == OP_INSERT_AT && pos_gt) begin
                        rsp_status_in = STAT_BAD_INDEX;
                     end else if (is_full) begin
                        rsp_status_in = STAT_FULL;
                     end else if (opcode == OP_APPEND || is_empty ||
                                  (opcode == OP_INSERT_AT && !pos_lt)) begin
                        mem_we   = 1'b1;
                        wr_addr  = AW'(count_ff);
                        wr_data  = req_item_value;
                        count_in = count_ff + 1'b1;
                     end else begin
                        rsp_strobe_in = 1'b0;
                        pos_in        = (opcode == OP_PREPEND) ? '0 : AW'(req_position);
                        stop_in       = (opcode == OP_PREPEND) ? '0 : AW'(req_position);
                        ptr_in        = tail_idx;
                        reading_in    = 1'b1;
                     end
                  end
                  OP_REMOVE_FIRST, OP_REMOVE_LAST, OP_REMOVE_AT: begin
                     if (is_empty) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        rsp_strobe_in = 1'b0;
                        if (opcode == OP_REMOVE_FIRST) begin
                           pos_in = '0;
                           ptr_in = '0;
                        end else if (opcode == OP_REMOVE_LAST || !pos_lt) begin
                           pos_in = tail_idx;
                           ptr_in = tail_idx;
                        end else begin
                           pos_in = AW'(req_position);
                           ptr_in = AW'(req_position);
                        end
                        stop_in    = tail_idx;
                        reading_in = 1'b1;
                     end
                  end
                  OP_REMOVE_VALUE, OP_DUMP: begin
                     if (is_empty) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        rsp_strobe_in = 1'b0;
                        ptr_in        = '0;
                        stop_in       = tail_idx;
                        reading_in    = 1'b1;
                     end
                  end
                  default: rsp_strobe_in = 1'b0;
               endcase
            end
         end
         S_INSERT: begin
            if (rvalid_ff) begin
               mem_we  = 1'b1;
               wr_addr = rdidx_ff + 1'b1;
               wr_data = rdata_ff;
            end else if (!reading_ff) begin
               mem_we        = 1'b1;
               wr_addr       = pos_ff;
               wr_data       = val_ff;
               count_in      = count_ff + 1'b1;
               rsp_strobe_in = 1'b1;
               rsp_last_in   = 1'b1;
            end
         end
         S_REMOVE: begin
            if (rvalid_ff) begin
               if (rdidx_ff == pos_ff) begin
                  removed_in = rdata_ff;
               end else begin
                  mem_we  = 1'b1;
                  wr_addr = rdidx_ff - 1'b1;
                  wr_data = rdata_ff;
               end
            end else if (!reading_ff) begin
               count_in       = count_ff - 1'b1;
               rsp_strobe_in  = 1'b1;
               rsp_element_in = removed_ff;
               rsp_last_in    = 1'b1;
            end
         end
         S_SEARCH: begin
            if (match) begin
               removed_in = rdata_ff;
               pos_in     = rdidx_ff;
            end else if (done) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = STAT_NOT_FOUND;
               rsp_last_in   = 1'b1;
            end
         end
         S_DUMP: begin
            if (rvalid_ff) begin
               rsp_strobe_in  = 1'b1;
               rsp_element_in = rdata_ff;
               rsp_last_in    = (rdidx_ff == stop_ff);
            end
         end
         default: rsp_strobe_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         reading_ff    <= 1'b0;
         rvalid_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         reading_ff    <= reading_in;
         rvalid_ff     <= rvalid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff         <= val_in;
      pos_ff         <= pos_in;
      stop_ff        <= stop_in;
      ptr_ff         <= ptr_in;
      rdidx_ff       <= rdidx_in;
      removed_ff     <= removed_in;
      rsp_element_ff <= rsp_element_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_element     = rsp_element_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_length      = 6'(count_ff);
   assign rsp_last_of_run = rsp_last_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(CAPACITY), "count above capacity")
   `ASSERT_IMPLIES(a_no_rw_clash, clock, reset, mem_we && rd_en, wr_addr != rd_addr, "read and write hit one entry")
   `ASSERT_IMPLIES(a_run_busy, clock, reset, rsp_strobe && !rsp_last_of_run, busy, "dump result outside a dump")
   `ASSERT_NEXT(a_dump_starts, clock, reset, accept && opcode == OP_DUMP && !is_empty, busy && state_ff == S_DUMP, "dump did not start")

endmodule

>>> verif/bounded_ordered_list_engine_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list engine testbench
// Drives list requests with random gaps and checks every response against a
// scoreboard that keeps its own copy of the list and predicts each response.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_top_tb;
   import bole_pkg::*;

   localparam int LIST_CAPACITY = 32;
   localparam int RANDOM_REQUESTS = 500;
   localparam int STALL_LIMIT = 2000;

   typedef struct {
      logic signed [31:0] element;
      status_type         status;
      logic [5:0]         length;
      logic               last_of_run;
   } list_response_type;

   class ordered_list_scoreboard;
      logic signed [31:0] entries[$];
      list_response_type  pending_responses[$];
      int                 mismatches;

      function new();
         mismatches = 0;
      endfunction

      function void push_response(logic signed [31:0] element, status_type status,
                                  logic last_of_run);
         list_response_type resp;
         resp.element = element;
         resp.status = status;
         resp.length = 6'(entries.size());
         resp.last_of_run = last_of_run;
         pending_responses.push_back(resp);
      endfunction

      function void take_entry(int index);
         logic signed [31:0] taken;
         taken = entries[index];
         entries.delete(index);
         push_response(taken, STAT_OK, 1'b1);
      endfunction

      function void note_request(opcode_type opcode, logic signed [31:0] value,
                                 logic [5:0] position);
         int count;
         int index;
         count = entries.size();
         index = -1;
         case (opcode)
            OP_APPEND, OP_PREPEND: begin
               if (count >= LIST_CAPACITY) begin
                  push_response(32'sd0, STAT_FULL, 1'b1);
               end else begin
                  if (opcode == OP_APPEND) begin
                     entries.push_back(value);
                  end else begin
                     entries.push_front(value);
                  end
                  push_response(32'sd0, STAT_OK, 1'b1);
               end
            end
            OP_REMOVE_FIRST, OP_REMOVE_LAST, OP_REMOVE_AT: begin
               if (count == 0) begin
                  push_response(32'sd0, STAT_EMPTY, 1'b1);
               end else if (opcode == OP_REMOVE_FIRST) begin
                  take_entry(0);
               end else if (opcode == OP_REMOVE_LAST || int'(position) >= count) begin
                  take_entry(count - 1);
               end else begin
                  take_entry(int'(position));
               end
            end
            OP_REMOVE_VALUE: begin
               if (count == 0) begin
                  push_response(32'sd0, STAT_EMPTY, 1'b1);
               end else begin
                  for (int i = 0; i < count; i++) begin
                     if (index < 0 && entries[i] == value) begin
                        index = i;
                     end
                  end
                  if (index < 0) begin
                     push_response(32'sd0, STAT_NOT_FOUND, 1'b1);
                  end else begin
                     take_entry(index);
                  end
               end
            end
            OP_INSERT_AT: begin
               if (int'(position) > count) begin
                  push_response(32'sd0, STAT_BAD_INDEX, 1'b1);
               end else if (count >= LIST_CAPACITY) begin
                  push_response(32'sd0, STAT_FULL, 1'b1);
               end else begin
                  entries.insert(int'(position), value);
                  push_response(32'sd0, STAT_OK, 1'b1);
               end
            end
            default: begin
               if (count == 0) begin
                  push_response(32'sd0, STAT_EMPTY, 1'b1);
               end else begin
                  for (int i = 0; i < count; i++) begin
                     push_response(entries[i], STAT_OK, i == count - 1);
                  end
               end
            end
         endcase
      endfunction

      function void check_response(logic signed [31:0] element, logic [2:0] status,
                                   logic [5:0] length, logic last_of_run);
         list_response_type want;
         if (pending_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: response with none expected: element %0d status %0d",
                        $realtime, element, status);
            end
         end else begin
            want = pending_responses.pop_front();
            if (element !== want.element || status !== want.status ||
                length !== want.length || last_of_run !== want.last_of_run) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: expected element %0d status %0d length %0d last %0d",
                           $realtime, want.element, want.status, want.length,
                           want.last_of_run);
                  $display("%0t:      got element %0d status %0d length %0d last %0d",
                           $realtime, element, status, length, last_of_run);
               end
            end
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_opcode;
   logic signed [31:0] req_item_value;
   logic [5:0]         req_position;
   logic               rsp_strobe;
   logic signed [31:0] rsp_element;
   logic [2:0]         rsp_status;
   logic [5:0]         rsp_length;
   logic               rsp_last_of_run;

   ordered_list_scoreboard list_sb;
   int                     stall_cycles;

   bounded_ordered_list_engine_top #(
      .CAPACITY(LIST_CAPACITY)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_item_value(req_item_value),
      .req_position(req_position),
      .rsp_strobe(rsp_strobe),
      .rsp_element(rsp_element),
      .rsp_status(rsp_status),
      .rsp_length(rsp_length),
      .rsp_last_of_run(rsp_last_of_run)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            list_sb.check_response(rsp_element, rsp_status, rsp_length, rsp_last_of_run);
         end
         if (start && !busy) begin
            list_sb.note_request(opcode_type'(req_opcode), req_item_value, req_position);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_request(opcode_type opcode, logic signed [31:0] value,
                               logic [5:0] position);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_opcode <= opcode;
      req_item_value <= value;
      req_position <= position;
      do @(posedge clock); while (busy);
   endtask

   function automatic logic signed [31:0] draw_value();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick < 2) begin
         return 32'(signed'($urandom_range(0, 4)) - 2);
      end else if (pick == 2) begin
         case ($urandom_range(0, 2))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            default: return -32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   function automatic logic signed [31:0] draw_search_value();
      int count;
      count = list_sb.entries.size();
      if (count > 0 && $urandom_range(0, 9) < 7) begin
         return list_sb.entries[$urandom_range(0, count - 1)];
      end
      return draw_value();
   endfunction

   function automatic logic [5:0] draw_position();
      int count;
      count = list_sb.entries.size();
      if ($urandom_range(0, 3) == 0) begin
         return 6'($urandom_range(0, LIST_CAPACITY));
      end
      return 6'($urandom_range(0, count));
   endfunction

   function automatic opcode_type draw_opcode(bit filling);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         return OP_DUMP;
      end else if ((pick < 70) == filling) begin
         case ($urandom_range(0, 2))
            0: return OP_APPEND;
            1: return OP_PREPEND;
            default: return OP_INSERT_AT;
         endcase
      end
      case ($urandom_range(0, 3))
         0: return OP_REMOVE_FIRST;
         1: return OP_REMOVE_LAST;
         2: return OP_REMOVE_AT;
         default: return OP_REMOVE_VALUE;
      endcase
   endfunction

   initial begin
      opcode_type opcode;
      list_sb = new();
      reset <= 1'b1;
      start <= 1'b0;
      req_opcode <= OP_DUMP;
      req_item_value <= 32'sd0;
      req_position <= 6'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_request(OP_DUMP, 32'sd0, 6'd0);
      send_request(OP_REMOVE_FIRST, 32'sd0, 6'd0);
      send_request(OP_REMOVE_LAST, 32'sd0, 6'd0);
      send_request(OP_REMOVE_AT, 32'sd0, 6'd5);
      send_request(OP_REMOVE_VALUE, 32'sd0, 6'd0);
      send_request(OP_INSERT_AT, 32'sd1, 6'd1);
      send_request(OP_INSERT_AT, 32'sh7fff_ffff, 6'd0);
      send_request(OP_APPEND, 32'sh8000_0000, 6'd0);
      send_request(OP_PREPEND, -32'sd1, 6'd0);
      send_request(OP_INSERT_AT, 32'sd0, 6'd3);
      send_request(OP_INSERT_AT, 32'sh1234_5678, 6'd2);
      send_request(OP_APPEND, -32'sd1, 6'd0);
      send_request(OP_REMOVE_VALUE, 32'sd5, 6'd0);
      send_request(OP_REMOVE_VALUE, -32'sd1, 6'd0);
      send_request(OP_REMOVE_VALUE, 32'sh1234_5678, 6'd0);
      send_request(OP_DUMP, 32'sd0, 6'd0);
      send_request(OP_REMOVE_AT, 32'sd0, 6'd0);
      send_request(OP_REMOVE_AT, 32'sd0, 6'd32);
      send_request(OP_INSERT_AT, 32'sd3, 6'd32);
      send_request(OP_REMOVE_FIRST, 32'sd0, 6'd0);
      send_request(OP_REMOVE_LAST, 32'sd0, 6'd0);
      send_request(OP_DUMP, 32'sd0, 6'd0);

      for (int k = 0; k < RANDOM_REQUESTS; k++) begin
         opcode = draw_opcode(((k / 64) % 2) == 0);
         if (opcode == OP_REMOVE_VALUE) begin
            send_request(opcode, draw_search_value(), draw_position());
         end else begin
            send_request(opcode, draw_value(), draw_position());
         end
      end
      start <= 1'b0;

      while (list_sb.pending_responses.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (list_sb.mismatches == 0 && list_sb.pending_responses.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
